[hdl/aarm_pkg.sv]
// aarm_pkg: payload structs and fixed-point constants for the axis-angle
// rotation matrix builder. No dependencies.
`default_nettype none
package aarm_pkg;

  localparam int Iters = 16;

  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] TwoPiQ16  = 20'sd411775;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [15:0] OneQ14    = 16'sd16384;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic [1:0]         group_index;
    logic signed [15:0] entry_a;
    logic signed [15:0] entry_b;
    logic signed [15:0] entry_c;
    logic signed [15:0] entry_d;
    logic               is_last;
  } out_t;

  function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0:  atan_q16 = 20'sd51472;
      4'd1:  atan_q16 = 20'sd30386;
      4'd2:  atan_q16 = 20'sd16055;
      4'd3:  atan_q16 = 20'sd8150;
      4'd4:  atan_q16 = 20'sd4091;
      4'd5:  atan_q16 = 20'sd2047;
      4'd6:  atan_q16 = 20'sd1024;
      4'd7:  atan_q16 = 20'sd512;
      4'd8:  atan_q16 = 20'sd256;
      4'd9:  atan_q16 = 20'sd128;
      4'd10: atan_q16 = 20'sd64;
      4'd11: atan_q16 = 20'sd32;
      4'd12: atan_q16 = 20'sd16;
      4'd13: atan_q16 = 20'sd8;
      4'd14: atan_q16 = 20'sd4;
      default: atan_q16 = 20'sd2;
    endcase
  endfunction

endpackage
`default_nettype wire

[hdl/axis_angle_rotation_matrix_top.sv]
// Axis-angle rotation matrix builder: Rodrigues' formula, 4x4 homogeneous.
// Depends on aarm_pkg.
//
//  channel | direction | payload           | handshake
//  in      | request   | aarm_pkg::in_t    | in_valid / in_ready
//  out     | 4 results | aarm_pkg::out_t   | out_valid / out_ready
//
// The serializer emits one group per cycle while out_ready is high; new
// requests enter while earlier ones are in flight. The first group comes
// after range reduce, 16 CORDIC stages, two product stages, round and the
// output buffer. The pipeline advances only when its tail can drain, so a
// stall holds every stage. Reset clears all valid bits.
`default_nettype none
module axis_angle_rotation_matrix_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output      logic           in_ready,
  input  wire aarm_pkg::in_t  in_data,
  output      logic           out_valid,
  input  wire logic           out_ready,
  output      aarm_pkg::out_t out_data
);

  localparam int N = aarm_pkg::Iters;

  // matrix buffer feeding the serializer
  logic               mb_valid;
  logic [1:0]         grp;
  logic signed [15:0] m [0:8];

  logic adv;      // pipeline moves
  logic tail_v;
  logic last_go;
  // adv also opens when the final group drains this cycle
  assign adv = !tail_v || !mb_valid || last_go;
  assign in_ready = adv;

  // stage 0: widen and reduce
  logic               s0_v;
  logic signed [19:0] s0_th;
  logic               s0_neg;
  logic signed [15:0] s0_u, s0_vv, s0_w;
  logic signed [19:0] th_a, th_b, th_c;
  logic               neg_c;
  always_comb begin
    th_a = {in_data.angle, 4'b0};
    if (th_a > aarm_pkg::PiQ16) th_a = th_a - aarm_pkg::TwoPiQ16;
    if (th_a < -aarm_pkg::PiQ16) th_a = th_a + aarm_pkg::TwoPiQ16;
    th_b = th_a;
    neg_c = 1'b0;
    th_c = th_a;
    if (th_b > aarm_pkg::HalfPiQ16) begin
      th_c = aarm_pkg::PiQ16 - th_b;
      neg_c = 1'b1;
    end else if (th_b < -aarm_pkg::HalfPiQ16) begin
      th_c = -aarm_pkg::PiQ16 - th_b;
      neg_c = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (adv) s0_v <= in_valid;
    if (adv) begin
      s0_th <= th_c; s0_neg <= neg_c;
      s0_u <= in_data.axis_x; s0_vv <= in_data.axis_y; s0_w <= in_data.axis_z;
    end
  end

  // CORDIC stages
  logic               cv [0:N];
  logic signed [33:0] cx [0:N];
  logic signed [33:0] cy [0:N];
  logic signed [19:0] cz [0:N];
  logic               cn [0:N];
  logic signed [15:0] cu [0:N], cvv [0:N], cw [0:N];
  assign cv[0] = s0_v;  assign cx[0] = aarm_pkg::GainQ30; assign cy[0] = '0;
  assign cz[0] = s0_th; assign cn[0] = s0_neg;
  assign cu[0] = s0_u;  assign cvv[0] = s0_vv; assign cw[0] = s0_w;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [33:0] dx, dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else if (adv) cv[i+1] <= cv[i];
      if (adv) begin
        if (!cz[i][19]) begin
          cx[i+1] <= cx[i] - dx; cy[i+1] <= cy[i] + dy;
          cz[i+1] <= cz[i] - aarm_pkg::atan_q16(4'(i));
        end else begin
          cx[i+1] <= cx[i] + dx; cy[i+1] <= cy[i] - dy;
          cz[i+1] <= cz[i] + aarm_pkg::atan_q16(4'(i));
        end
        cn[i+1] <= cn[i]; cu[i+1] <= cu[i]; cvv[i+1] <= cvv[i]; cw[i+1] <= cw[i];
      end
    end
  end

  // round to c, s, t and form axis pair products
  logic signed [33:0] xr, yr;
  logic signed [19:0] cq, sq;
  assign xr = (cx[N] + 34'sd8192) >>> 14;
  assign yr = (cy[N] + 34'sd8192) >>> 14;
  assign cq = cn[N] ? -xr[19:0] : xr[19:0];
  assign sq = yr[19:0];

  logic               p1_v;
  logic signed [19:0] p1_c, p1_s;
  logic signed [18:0] p1_t;
  logic signed [31:0] p1_uu, p1_vv, p1_ww, p1_uv, p1_uw, p1_vw;
  logic signed [15:0] p1_u, p1_v2, p1_w;
  always_ff @(posedge clk) begin
    if (rst) p1_v <= 1'b0;
    else if (adv) p1_v <= cv[N];
    if (adv) begin
      p1_c <= cq; p1_s <= sq; p1_t <= 19'(21'sd65536 - 21'(cq));
      p1_uu <= cu[N] * cu[N]; p1_vv <= cvv[N] * cvv[N]; p1_ww <= cw[N] * cw[N];
      p1_uv <= cu[N] * cvv[N]; p1_uw <= cu[N] * cw[N]; p1_vw <= cvv[N] * cw[N];
      p1_u <= cu[N]; p1_v2 <= cvv[N]; p1_w <= cw[N];
    end
  end

  // multiply by t and s
  logic               p2_v;
  logic signed [50:0] p2_uu, p2_vv, p2_ww, p2_uv, p2_uw, p2_vw;
  logic signed [35:0] p2_us, p2_vs, p2_ws;
  logic signed [19:0] p2_c;
  always_ff @(posedge clk) begin
    if (rst) p2_v <= 1'b0;
    else if (adv) p2_v <= p1_v;
    if (adv) begin
      p2_uu <= 51'(p1_uu) * 51'(p1_t); p2_vv <= 51'(p1_vv) * 51'(p1_t);
      p2_ww <= 51'(p1_ww) * 51'(p1_t); p2_uv <= 51'(p1_uv) * 51'(p1_t);
      p2_uw <= 51'(p1_uw) * 51'(p1_t); p2_vw <= 51'(p1_vw) * 51'(p1_t);
      p2_us <= 36'(p1_u) * 36'(p1_s); p2_vs <= 36'(p1_v2) * 36'(p1_s);
      p2_ws <= 36'(p1_w) * 36'(p1_s); p2_c <= p1_c;
    end
  end

  // sums and saturating round
  function automatic logic signed [15:0] sat14(input logic signed [52:0] a);
    logic signed [52:0] r;
    r = (a + 53'sd536870912) >>> 30;
    if (r > 53'sd32767) sat14 = 16'sh7fff;
    else if (r < -53'sd32768) sat14 = 16'sh8000;
    else sat14 = r[15:0];
  endfunction

  logic signed [52:0] c44, us, vs, ws;
  assign c44 = 53'(p2_c) <<< 28;
  assign us  = 53'(p2_us) <<< 14;
  assign vs  = 53'(p2_vs) <<< 14;
  assign ws  = 53'(p2_ws) <<< 14;

  logic               p3_v;
  logic signed [15:0] p3_m [0:8];
  always_ff @(posedge clk) begin
    if (rst) p3_v <= 1'b0;
    else if (adv) p3_v <= p2_v;
    if (adv) begin
      p3_m[0] <= sat14(c44 + 53'(p2_uu));
      p3_m[1] <= sat14(53'(p2_uv) + ws);
      p3_m[2] <= sat14(53'(p2_uw) - vs);
      p3_m[3] <= sat14(53'(p2_uv) - ws);
      p3_m[4] <= sat14(c44 + 53'(p2_vv));
      p3_m[5] <= sat14(53'(p2_vw) + us);
      p3_m[6] <= sat14(53'(p2_uw) + vs);
      p3_m[7] <= sat14(53'(p2_vw) - us);
      p3_m[8] <= sat14(c44 + 53'(p2_ww));
    end
  end
  assign tail_v = p3_v;

  // serializer: loads when empty or when the last group leaves
  logic load;
  assign last_go = mb_valid && out_ready && grp == 2'd3;
  assign load = p3_v && adv;
  always_ff @(posedge clk) begin
    if (rst) begin
      mb_valid <= 1'b0;
      grp <= 2'd0;
    end else begin
      if (load) begin
        mb_valid <= 1'b1;
        grp <= 2'd0;
      end else if (mb_valid && out_ready) begin
        grp <= grp + 2'd1;
        if (grp == 2'd3) mb_valid <= 1'b0;
      end
    end
    if (load) m <= p3_m;
  end

  always_comb begin
    out_data.group_index = grp;
    out_data.is_last = (grp == 2'd3);
    case (grp)
      2'd0: begin
        out_data.entry_a = m[0]; out_data.entry_b = m[1];
        out_data.entry_c = m[2]; out_data.entry_d = '0;
      end
      2'd1: begin
        out_data.entry_a = m[3]; out_data.entry_b = m[4];
        out_data.entry_c = m[5]; out_data.entry_d = '0;
      end
      2'd2: begin
        out_data.entry_a = m[6]; out_data.entry_b = m[7];
        out_data.entry_c = m[8]; out_data.entry_d = '0;
      end
      default: begin
        out_data.entry_a = '0; out_data.entry_b = '0;
        out_data.entry_c = '0; out_data.entry_d = aarm_pkg::OneQ14;
      end
    endcase
  end
  assign out_valid = mb_valid;

endmodule
`default_nettype wire

[hdl/aarm_checker.sv]
// Port-level checker for the rotation matrix builder, bound to the top level.
// Depends on aarm_pkg.
`default_nettype none
module aarm_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire aarm_pkg::out_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.is_last == (out_data.group_index == 2'd3))
    else $error("is_last mismatch");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.is_last |=>
      out_valid && out_data.group_index == $past(out_data.group_index) + 2'd1)
    else $error("groups out of order");
  a_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_last |-> out_data.entry_d == aarm_pkg::OneQ14)
    else $error("entry 15 not one");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule

bind axis_angle_rotation_matrix_top aarm_checker u_aarm_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

[sim/axis_angle_rotation_matrix_top_tb.sv]
// Testbench for axis_angle_rotation_matrix_top: directed table then random requests,
// each checked group by group against an in-bench fixed-point Rodrigues predictor.
// Depends on aarm_pkg and the RTL top level.
`default_nettype none
module axis_angle_rotation_matrix_top_tb;

  localparam int NumRandom = 410;
  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 40;

  typedef struct {
    aarm_pkg::in_t  req;
    logic           has_fixed;
    aarm_pkg::out_t fixed_g0;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  aarm_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  aarm_pkg::out_t out_data;

  aarm_pkg::out_t groups_due[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit stim_done = 1'b0;

  axis_angle_rotation_matrix_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic signed [15:0] round_sat(longint acc);
    longint r;
    r = floor_shr(acc + (64'sd1 <<< 29), 30);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // cos/sin in Q.16 by folded CORDIC, 16 rotations
  task automatic cordic_sincos(input longint theta, output longint c, output longint s);
    longint atan_q[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (theta > 205887) theta -= 411775;
    if (theta < -205887) theta += 411775;
    if (theta > 102944) begin
      theta = 205887 - theta;
      flip = 1'b1;
    end else if (theta < -102944) begin
      theta = -205887 - theta;
      flip = 1'b1;
    end
    z = theta;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q[i];
      end else begin
        x += dx; y -= dy; z += atan_q[i];
      end
    end
    x = floor_shr(x + 8192, 14);
    y = floor_shr(y + 8192, 14);
    c = flip ? -x : x;
    s = y;
  endtask

  task automatic predict_matrix(input aarm_pkg::in_t req);
    longint u, v, w, c, s, t, c44;
    logic signed [15:0] m[16];
    aarm_pkg::out_t g;
    u = req.axis_x; v = req.axis_y; w = req.axis_z;
    cordic_sincos(longint'(req.angle) * 16, c, s);
    t = 65536 - c;
    c44 = c * (64'sd1 <<< 28);
    m[0] = round_sat(c44 + u * u * t);
    m[1] = round_sat(u * v * t + w * s * 16384);
    m[2] = round_sat(u * w * t - v * s * 16384);
    m[3] = '0;
    m[4] = round_sat(u * v * t - w * s * 16384);
    m[5] = round_sat(c44 + v * v * t);
    m[6] = round_sat(w * v * t + u * s * 16384);
    m[7] = '0;
    m[8] = round_sat(u * w * t + v * s * 16384);
    m[9] = round_sat(v * w * t - u * s * 16384);
    m[10] = round_sat(c44 + w * w * t);
    m[11] = '0; m[12] = '0; m[13] = '0; m[14] = '0;
    m[15] = aarm_pkg::OneQ14;
    for (int k = 0; k < 4; k++) begin
      g.group_index = k[1:0];
      g.entry_a = m[4 * k];
      g.entry_b = m[4 * k + 1];
      g.entry_c = m[4 * k + 2];
      g.entry_d = m[4 * k + 3];
      g.is_last = (k == 3);
      groups_due.push_back(g);
    end
  endtask

  function automatic aarm_pkg::in_t random_request();
    aarm_pkg::in_t r;
    int mode;
    mode = $urandom_range(0, 9);
    r.axis_x = $urandom; r.axis_y = $urandom; r.axis_z = $urandom;
    r.angle = $urandom;
    if (mode < 6) begin
      // bounded axis: x within +-1.0, y and z within +-0.5 (Q14)
      r.axis_x = $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      r.axis_y = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
      r.axis_z = $signed(16'($urandom_range(0, 16384))) - 16'sd8192;
    end
    return r;
  endfunction

  // called at a falling edge; leaves at the falling edge after the accept
  task automatic send_request(input aarm_pkg::in_t req);
    while ($urandom_range(0, 99) < 13 && !quiet) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_matrix(req);
    @(negedge clk);
  endtask

  // sink side: random stalls, sampled at the rising edge
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    aarm_pkg::out_t exp_g;
    if (!rst && out_valid && out_ready) begin
      if (groups_due.size() == 0) begin
        $error("unexpected result group %0d", out_data.group_index);
        errors++;
      end else begin
        exp_g = groups_due.pop_front();
        if (out_data.group_index !== exp_g.group_index) begin
          $error("group_index exp %0d got %0d", exp_g.group_index, out_data.group_index);
          errors++;
        end
        if (out_data.entry_a !== exp_g.entry_a) begin
          $error("entry_a exp %0d got %0d", exp_g.entry_a, out_data.entry_a);
          errors++;
        end
        if (out_data.entry_b !== exp_g.entry_b) begin
          $error("entry_b exp %0d got %0d", exp_g.entry_b, out_data.entry_b);
          errors++;
        end
        if (out_data.entry_c !== exp_g.entry_c) begin
          $error("entry_c exp %0d got %0d", exp_g.entry_c, out_data.entry_c);
          errors++;
        end
        if (out_data.entry_d !== exp_g.entry_d) begin
          $error("entry_d exp %0d got %0d", exp_g.entry_d, out_data.entry_d);
          errors++;
        end
        if (out_data.is_last !== exp_g.is_last) begin
          $error("is_last exp %0d got %0d", exp_g.is_last, out_data.is_last);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else if (!stim_done || groups_due.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("[axis_angle_rotation_matrix_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    aarm_pkg::out_t id0;
    id0.group_index = 2'd0; id0.entry_a = aarm_pkg::OneQ14; id0.entry_b = '0;
    id0.entry_c = '0; id0.entry_d = '0; id0.is_last = 1'b0;
    // zero angle with unit x axis: identity, typed in
    rw.req = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}; rw.has_fixed = 1; rw.fixed_g0 = id0;
    rows.push_back(rw);
    rw.has_fixed = 0;
    // angle extremes, wrap and fold regions, both signs
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sh7FFF}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sh8000}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, 16'sd6434}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, -16'sd6434}, 0, '0});
    rows.push_back('{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd12868}, 0, '0});
    rows.push_back('{'{16'sd9459, 16'sd9459, 16'sd9459, -16'sd12868}, 0, '0});
    rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd13000}, 0, '0});
    rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, -16'sd13000}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, -16'sd16384, 16'sd25736}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, -16'sd16384, 16'sd3217}, 0, '0});
    // non-unit axes, saturation both ways
    rows.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sd12868}, 0, '0});
    rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sd12868}, 0, '0});
    rows.push_back('{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd6434}, 0, '0});
    rows.push_back('{'{16'sh8000, 16'sh7FFF, 16'sh8000, -16'sd6434}, 0, '0});
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sh7FFF}, 0, '0});
    rows.push_back('{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF}, 0, '0});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].has_fixed) groups_due[groups_due.size() - 4] = rows[i].fixed_g0;
    end
    for (int n = 0; n < NumRandom; n++) begin
      quiet = (n >= 150 && n < 230);
      send_request(random_request());
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    stim_done = 1'b1;
    while (groups_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("[axis_angle_rotation_matrix_top] OK");
    else $display("[axis_angle_rotation_matrix_top] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
